// ===== hdl/assert_macros.svh =====
// Assertion macros for the sm83 execution unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define SM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sm83_alu_pkg.sv =====
`default_nettype none

package sm83_alu_pkg;

    localparam int unsigned OpW   = 4;
    localparam int unsigned SubW  = 3;
    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 16;
    localparam int unsigned FlagW = 4;

    localparam int unsigned InUserW  = OpW + SubW;
    localparam int unsigned InDataW  = 56;
    localparam int unsigned OutDataW = 32;

    typedef enum logic [OpW-1:0] {
        OP_ALU8     = 4'd0,
        OP_SHIFT    = 4'd1,
        OP_BITTEST  = 4'd2,
        OP_BITRESET = 4'd3,
        OP_BITSET   = 4'd4,
        OP_INC      = 4'd5,
        OP_DEC      = 4'd6,
        OP_DAA      = 4'd7,
        OP_ROTACC   = 4'd8,
        OP_CPL      = 4'd9,
        OP_SCF      = 4'd10,
        OP_CCF      = 4'd11,
        OP_ADD16    = 4'd12,
        OP_ADDSPOFF = 4'd13
    } t_op;

    typedef enum logic [SubW-1:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBC = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CP  = 3'd7
    } t_alu_op;

    typedef enum logic [SubW-1:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } t_shift_op;

    // Flag bit positions
    localparam int unsigned FlagZ = 3;
    localparam int unsigned FlagN = 2;
    localparam int unsigned FlagH = 1;
    localparam int unsigned FlagC = 0;

    localparam logic [ByteW-1:0] DaaLimit = 8'h99;
    localparam logic [3:0]       DaaDigit = 4'd9;

endpackage

`default_nettype wire

// ===== hdl/sm83_alu_flags_unit.sv =====
// Path: each input beat passes through the input register, then the result register.
// Throughput: one beat per cycle; the single pass between the two registers sets it.
// Backpressure stalls both stages together once both hold a beat; while the input
// register is empty a held result does not block the input stage.
// Reset: synchronous, active low; clears both stage valids, payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module sm83_alu_flags_unit
    import sm83_alu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output      logic                o_s_tready,
    // operand_a, operand_b, flags_in, word_a, word_b, zero pad
    input  wire logic [InDataW-1:0]  i_s_tdata,
    // operation, sub_op
    input  wire logic [InUserW-1:0]  i_s_tuser,
    output      logic                o_m_tvalid,
    input  wire logic                i_m_tready,
    // result_byte, result_word, flags_out, write_back, zero pad
    output      logic [OutDataW-1:0] o_m_tdata
);

    logic              r_v1;
    t_op               r_op;
    logic [SubW-1:0]   r_sub;
    logic [ByteW-1:0]  r_a;
    logic [ByteW-1:0]  r_b;
    logic [FlagW-1:0]  r_flags;
    logic [WordW-1:0]  r_wa;
    logic [WordW-1:0]  r_wb;

    logic              r_v2;
    logic [ByteW-1:0]  r_res_byte;
    logic [WordW-1:0]  r_res_word;
    logic [FlagW-1:0]  r_res_flags;
    logic              r_res_wb;

    logic [ByteW-1:0]  n_byte;
    logic [WordW-1:0]  n_word;
    logic [FlagW-1:0]  n_flags;
    logic              n_wb;

    logic              en1;
    logic              en2;

    logic              cin;
    logic              add_cin;
    logic              sub_cin;
    logic [ByteW:0]    add_sum;
    logic [4:0]        add_half;
    logic [ByteW:0]    sub_sum;
    logic [4:0]        sub_half;
    logic [ByteW-1:0]  inc_res;
    logic [ByteW-1:0]  dec_res;
    logic [ByteW-1:0]  bit_mask;
    logic [ByteW:0]    sh_out;
    logic [ByteW:0]    rot_out;
    logic              daa_hi;
    logic              daa_lo;
    logic [ByteW-1:0]  daa_adj;
    logic [ByteW-1:0]  daa_res;
    logic [WordW:0]    w_sum;
    logic [12:0]       w_half;
    logic [WordW-1:0]  sp_sum;
    logic [4:0]        sp_half;
    logic [ByteW:0]    sp_carry;

    function automatic logic [ByteW:0] shift_byte(
        input logic [SubW-1:0]  kind,
        input logic [ByteW-1:0] a,
        input logic             c_in
    );
        logic [ByteW:0] res;
        case (kind)
            SH_RLC:  res = {a[7], a[6:0], a[7]};
            SH_RRC:  res = {a[0], a[0], a[7:1]};
            SH_RL:   res = {a[7], a[6:0], c_in};
            SH_RR:   res = {a[0], c_in, a[7:1]};
            SH_SLA:  res = {a[7], a[6:0], 1'b0};
            SH_SRA:  res = {a[0], a[7], a[7:1]};
            SH_SWAP: res = {1'b0, a[3:0], a[7:4]};
            SH_SRL:  res = {a[0], 1'b0, a[7:1]};
            default: res = '0;
        endcase
        return res;
    endfunction

    assign en2        = !r_v2 || i_m_tready;
    assign en1        = !r_v1 || en2;
    assign o_s_tready = en1;
    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = {3'b000, r_res_wb, r_res_flags, r_res_word, r_res_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_s_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_s_tvalid) begin
            r_op    <= t_op'(i_s_tuser[OpW-1:0]);
            r_sub   <= i_s_tuser[OpW+SubW-1:OpW];
            r_a     <= i_s_tdata[7:0];
            r_b     <= i_s_tdata[15:8];
            r_flags <= i_s_tdata[19:16];
            r_wa    <= i_s_tdata[35:20];
            r_wb    <= i_s_tdata[51:36];
        end
        if (en2 && r_v1) begin
            r_res_byte  <= n_byte;
            r_res_word  <= n_word;
            r_res_flags <= n_flags;
            r_res_wb    <= n_wb;
        end
    end

    assign cin      = r_flags[FlagC];
    assign add_cin  = (r_sub == ALU_ADC) && cin;
    assign sub_cin  = (r_sub == ALU_SBC) ? !cin : 1'b1;
    assign add_sum  = {1'b0, r_a} + {1'b0, r_b} + {8'd0, add_cin};
    assign add_half = {1'b0, r_a[3:0]} + {1'b0, r_b[3:0]} + {4'd0, add_cin};
    assign sub_sum  = {1'b0, r_a} + {1'b0, ~r_b} + {8'd0, sub_cin};
    assign sub_half = {1'b0, r_a[3:0]} + {1'b0, ~r_b[3:0]} + {4'd0, sub_cin};
    assign inc_res  = r_a + 8'd1;
    assign dec_res  = r_a - 8'd1;
    assign bit_mask = 8'd1 << r_sub;
    assign sh_out   = shift_byte(r_sub, r_a, cin);
    assign rot_out  = shift_byte({1'b0, r_sub[1:0]}, r_a, cin);

    assign daa_hi  = ((r_a > DaaLimit) && !r_flags[FlagN]) || r_flags[FlagC];
    assign daa_lo  = ((r_a[3:0] > DaaDigit) && !r_flags[FlagN]) || r_flags[FlagH];
    assign daa_adj = {1'b0, daa_hi, daa_hi, 2'b00, daa_lo, daa_lo, 1'b0};
    assign daa_res = r_flags[FlagN] ? (r_a - daa_adj) : (r_a + daa_adj);

    assign w_sum    = {1'b0, r_wa} + {1'b0, r_wb};
    assign w_half   = {1'b0, r_wa[11:0]} + {1'b0, r_wb[11:0]};
    assign sp_sum   = r_wa + {{8{r_b[7]}}, r_b};
    assign sp_half  = {1'b0, r_wa[3:0]} + {1'b0, r_b[3:0]};
    assign sp_carry = {1'b0, r_wa[7:0]} + {1'b0, r_b};

    always_comb begin
        n_byte  = '0;
        n_word  = '0;
        n_flags = r_flags;
        n_wb    = 1'b1;
        case (r_op)
            OP_ALU8: begin
                n_byte = r_a;
                case (r_sub)
                    ALU_ADD, ALU_ADC: begin
                        n_byte  = add_sum[7:0];
                        n_flags = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
                    end
                    ALU_SUB, ALU_SBC: begin
                        n_byte  = sub_sum[7:0];
                        n_flags = {sub_sum[7:0] == 8'd0, 1'b1, !sub_half[4], !sub_sum[8]};
                    end
                    ALU_CP: begin
                        n_wb    = 1'b0;
                        n_flags = {sub_sum[7:0] == 8'd0, 1'b1, !sub_half[4], !sub_sum[8]};
                    end
                    ALU_AND: begin
                        n_byte  = r_a & r_b;
                        n_flags = {(r_a & r_b) == 8'd0, 3'b010};
                    end
                    ALU_XOR: begin
                        n_byte  = r_a ^ r_b;
                        n_flags = {(r_a ^ r_b) == 8'd0, 3'b000};
                    end
                    default: begin
                        n_byte  = r_a | r_b;
                        n_flags = {(r_a | r_b) == 8'd0, 3'b000};
                    end
                endcase
            end
            OP_SHIFT: begin
                n_byte  = sh_out[7:0];
                n_flags = {sh_out[7:0] == 8'd0, 2'b00, sh_out[8]};
            end
            OP_BITTEST: begin
                n_byte  = r_a;
                n_wb    = 1'b0;
                n_flags = {(r_a & bit_mask) == 8'd0, 2'b01, cin};
            end
            OP_BITRESET: n_byte = r_a & ~bit_mask;
            OP_BITSET:   n_byte = r_a | bit_mask;
            OP_INC: begin
                n_byte  = inc_res;
                n_flags = {inc_res == 8'd0, 1'b0, inc_res[3:0] == 4'h0, cin};
            end
            OP_DEC: begin
                n_byte  = dec_res;
                n_flags = {dec_res == 8'd0, 1'b1, dec_res[3:0] == 4'hf, cin};
            end
            OP_DAA: begin
                n_byte  = daa_res;
                n_flags = {daa_res == 8'd0, r_flags[FlagN], 1'b0, daa_hi};
            end
            OP_ROTACC: begin
                n_byte  = rot_out[7:0];
                n_flags = {3'b000, rot_out[8]};
            end
            OP_CPL: begin
                n_byte  = ~r_a;
                n_flags = r_flags | 4'b0110;
            end
            OP_SCF: begin
                n_byte  = r_a;
                n_flags = {r_flags[FlagZ], 3'b001};
            end
            OP_CCF: begin
                n_byte  = r_a;
                n_flags = {r_flags[FlagZ], 2'b00, !cin};
            end
            OP_ADD16: begin
                n_word  = w_sum[15:0];
                n_flags = {r_flags[FlagZ], 1'b0, w_half[12], w_sum[16]};
            end
            OP_ADDSPOFF: begin
                n_word  = sp_sum;
                n_flags = {2'b00, sp_half[4], sp_carry[8]};
            end
            default: n_wb = 1'b0;
        endcase
    end

    `SM_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_m_tvalid,
        "result valid straight after reset")
    `SM_ASSERT(a_stage1_holds, i_clk, i_rst_n,
        (r_v1 && r_v2 && !i_m_tready) |=> (r_v1 && $stable(r_a) && $stable(r_op)),
        "input stage lost or changed a beat while the result stalled")
    `SM_ASSERT(a_word_ops_no_byte, i_clk, i_rst_n,
        (en2 && r_v1 && (r_op == OP_ADD16 || r_op == OP_ADDSPOFF)) |=> (r_res_byte == 8'd0),
        "word operation left a byte result")
    `SM_ASSERT(a_cp_no_write, i_clk, i_rst_n,
        (en2 && r_v1 && r_op == OP_ALU8 && r_sub == ALU_CP) |=> !r_res_wb,
        "compare wrote back")

endmodule

`default_nettype wire

// ===== dv/sm83_alu_flags_unit_test.sv =====
`timescale 1ns / 1ps

module sm83_alu_flags_unit_test;
    import sm83_alu_pkg::*;

    localparam logic [OpW-1:0] OpSpareLo = 4'd14;
    localparam logic [OpW-1:0] OpSpareHi = 4'd15;
    localparam int unsigned RandomOps = 1550;
    localparam int unsigned StallLimit = 2000;
    localparam int unsigned DrainCycles = 8;

    typedef struct {
        logic [OpW-1:0]   op;
        logic [SubW-1:0]  sub;
        logic [ByteW-1:0] a;
        logic [ByteW-1:0] b;
        logic [FlagW-1:0] fl;
        logic [WordW-1:0] wa;
        logic [WordW-1:0] wb;
    } t_alu_item;

    typedef struct {
        logic [ByteW-1:0] rbyte;
        logic [WordW-1:0] rword;
        logic [FlagW-1:0] fl;
        logic             wr;
    } t_alu_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;  // operand_a, operand_b, flags_in, word_a, word_b, pad
    logic [InUserW-1:0]  s_tuser = '0;  // operation, sub_op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;       // result_byte, result_word, flags_out, write_back, pad

    t_alu_item ops_to_send[$];
    t_alu_res  alu_results_due[$];
    t_alu_item op_on_bus;
    int        gap_left = 0;
    int        stall_left = 0;
    int        idle_cycles = 0;
    int        mismatches = 0;
    logic      no_idle = 1'b0;

    sm83_alu_flags_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    function automatic t_alu_res sm83_execute(t_alu_item x);
        t_alu_res         r;
        logic [8:0]       v9;
        logic [4:0]       h5;
        logic [12:0]      h13;
        logic [16:0]      v17;
        logic [ByteW-1:0] v;
        logic [ByteW-1:0] adj;
        logic             c;
        logic             cin;
        logic             nf;
        r.rbyte = '0;
        r.rword = '0;
        r.fl = x.fl;
        r.wr = 1'b1;
        cin = x.fl[FlagC];
        case (x.op)
            OP_ALU8: begin
                r.rbyte = x.a;
                r.fl = '0;
                case (x.sub)
                    ALU_ADD, ALU_ADC: begin
                        c = (x.sub == ALU_ADC) ? cin : 1'b0;
                        v9 = {1'b0, x.a} + {1'b0, x.b} + {8'd0, c};
                        h5 = {1'b0, x.a[3:0]} + {1'b0, x.b[3:0]} + {4'd0, c};
                        r.rbyte = v9[7:0];
                        r.fl[FlagC] = v9[8];
                        r.fl[FlagH] = h5[4];
                        v = v9[7:0];
                    end
                    ALU_SUB, ALU_SBC, ALU_CP: begin
                        c = (x.sub == ALU_SBC) ? ~cin : 1'b1;
                        v9 = {1'b0, x.a} + {1'b0, ~x.b} + {8'd0, c};
                        h5 = {1'b0, x.a[3:0]} + {1'b0, ~x.b[3:0]} + {4'd0, c};
                        r.fl[FlagN] = 1'b1;
                        r.fl[FlagC] = ~v9[8];
                        r.fl[FlagH] = ~h5[4];
                        if (x.sub == ALU_CP) begin
                            r.wr = 1'b0;
                        end else begin
                            r.rbyte = v9[7:0];
                        end
                        v = v9[7:0];
                    end
                    ALU_AND: begin
                        v = x.a & x.b;
                        r.rbyte = v;
                        r.fl[FlagH] = 1'b1;
                    end
                    ALU_XOR: begin
                        v = x.a ^ x.b;
                        r.rbyte = v;
                    end
                    default: begin
                        v = x.a | x.b;
                        r.rbyte = v;
                    end
                endcase
                r.fl[FlagZ] = (v == 0);
            end
            OP_SHIFT, OP_ROTACC: begin
                case ((x.op == OP_ROTACC) ? {1'b0, x.sub[1:0]} : x.sub)
                    SH_RLC:  begin c = x.a[7]; v = {x.a[6:0], x.a[7]}; end
                    SH_RRC:  begin c = x.a[0]; v = {x.a[0], x.a[7:1]}; end
                    SH_RL:   begin c = x.a[7]; v = {x.a[6:0], cin}; end
                    SH_RR:   begin c = x.a[0]; v = {cin, x.a[7:1]}; end
                    SH_SLA:  begin c = x.a[7]; v = {x.a[6:0], 1'b0}; end
                    SH_SRA:  begin c = x.a[0]; v = {x.a[7], x.a[7:1]}; end
                    SH_SWAP: begin c = 1'b0;   v = {x.a[3:0], x.a[7:4]}; end
                    default: begin c = x.a[0]; v = {1'b0, x.a[7:1]}; end
                endcase
                r.rbyte = v;
                r.fl = '0;
                r.fl[FlagC] = c;
                if (x.op == OP_SHIFT) begin
                    r.fl[FlagZ] = (v == 0);
                end
            end
            OP_BITTEST: begin
                r.rbyte = x.a;
                r.wr = 1'b0;
                r.fl = '0;
                r.fl[FlagC] = cin;
                r.fl[FlagH] = 1'b1;
                r.fl[FlagZ] = ~x.a[x.sub];
            end
            OP_BITRESET: r.rbyte = x.a & ~(8'd1 << x.sub);
            OP_BITSET:   r.rbyte = x.a | (8'd1 << x.sub);
            OP_INC: begin
                r.rbyte = x.a + 8'd1;
                r.fl = '0;
                r.fl[FlagC] = cin;
                r.fl[FlagZ] = (r.rbyte == 0);
                r.fl[FlagH] = (r.rbyte[3:0] == 4'h0);
            end
            OP_DEC: begin
                r.rbyte = x.a - 8'd1;
                r.fl = '0;
                r.fl[FlagC] = cin;
                r.fl[FlagN] = 1'b1;
                r.fl[FlagZ] = (r.rbyte == 0);
                r.fl[FlagH] = (r.rbyte[3:0] == 4'hf);
            end
            OP_DAA: begin
                nf = x.fl[FlagN];
                adj = '0;
                c = 1'b0;
                if ((x.a > DaaLimit && !nf) || cin) begin
                    adj = 8'h60;
                    c = 1'b1;
                end
                if ((x.a[3:0] > DaaDigit && !nf) || x.fl[FlagH]) begin
                    adj[2:1] = 2'b11;
                end
                r.rbyte = nf ? (x.a - adj) : (x.a + adj);
                r.fl = '0;
                r.fl[FlagN] = nf;
                r.fl[FlagC] = c;
                r.fl[FlagZ] = (r.rbyte == 0);
            end
            OP_CPL: begin
                r.rbyte = ~x.a;
                r.fl[FlagN] = 1'b1;
                r.fl[FlagH] = 1'b1;
            end
            OP_SCF, OP_CCF: begin
                r.rbyte = x.a;
                r.fl = '0;
                r.fl[FlagZ] = x.fl[FlagZ];
                r.fl[FlagC] = (x.op == OP_SCF) ? 1'b1 : ~cin;
            end
            OP_ADD16: begin
                v17 = {1'b0, x.wa} + {1'b0, x.wb};
                h13 = {1'b0, x.wa[11:0]} + {1'b0, x.wb[11:0]};
                r.rword = v17[15:0];
                r.fl = '0;
                r.fl[FlagZ] = x.fl[FlagZ];
                r.fl[FlagC] = v17[16];
                r.fl[FlagH] = h13[12];
            end
            OP_ADDSPOFF: begin
                v9 = {1'b0, x.wa[7:0]} + {1'b0, x.b};
                h5 = {1'b0, x.wa[3:0]} + {1'b0, x.b[3:0]};
                r.rword = x.wa + {{8{x.b[7]}}, x.b};
                r.fl = '0;
                r.fl[FlagC] = v9[8];
                r.fl[FlagH] = h5[4];
            end
            default: r.wr = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_alu_item make_op(logic [OpW-1:0] op, logic [SubW-1:0] sub,
                                          logic [ByteW-1:0] a, logic [ByteW-1:0] b,
                                          logic [FlagW-1:0] fl, logic [WordW-1:0] wa,
                                          logic [WordW-1:0] wb);
        t_alu_item x;
        x.op = op;
        x.sub = sub;
        x.a = a;
        x.b = b;
        x.fl = fl;
        x.wa = wa;
        x.wb = wb;
        return x;
    endfunction

    // bias towards carry and digit boundaries
    function automatic logic [ByteW-1:0] pick_byte();
        logic [ByteW-1:0] edges[8] = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h0f, 8'h10, 8'h99, 8'h9a};
        if ($urandom_range(0, 3) == 0) begin
            return edges[3'($urandom_range(0, 7))];
        end
        return ByteW'($urandom_range(0, 255));
    endfunction

    function automatic logic [WordW-1:0] pick_word();
        logic [WordW-1:0] edges[6] = '{16'h0000, 16'hffff, 16'h0fff, 16'h1000, 16'h00ff, 16'h8000};
        if ($urandom_range(0, 4) == 0) begin
            return edges[3'($urandom_range(0, 5))];
        end
        return WordW'($urandom_range(0, 65535));
    endfunction

    task automatic report(string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                alu_results_due.push_back(sm83_execute(op_on_bus));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (ops_to_send.size() != 0) begin
                    op_on_bus = ops_to_send.pop_front();
                    s_tdata <= {4'b0, op_on_bus.wb, op_on_bus.wa, op_on_bus.fl,
                                op_on_bus.b, op_on_bus.a};
                    s_tuser <= {op_on_bus.sub, op_on_bus.op};
                    s_tvalid <= 1'b1;
                    gap_left <= no_idle ? 0 : $urandom_range(0, 5);
                    if ($urandom_range(0, 99) == 0) begin
                        no_idle <= ~no_idle;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        int       n;
        t_alu_res want;
        n = stall_left;
        if (!i_rst_n) begin
            n = 0;
        end else if (m_tvalid && m_tready) begin
            if (alu_results_due.size() == 0) begin
                report($sformatf("result beat %h with nothing due", m_tdata));
            end else begin
                want = alu_results_due.pop_front();
                if (m_tdata[7:0] !== want.rbyte)
                    report($sformatf("result_byte %h, want %h", m_tdata[7:0], want.rbyte));
                if (m_tdata[23:8] !== want.rword)
                    report($sformatf("result_word %h, want %h", m_tdata[23:8], want.rword));
                if (m_tdata[27:24] !== want.fl)
                    report($sformatf("flags_out %b, want %b", m_tdata[27:24], want.fl));
                if (m_tdata[28] !== want.wr)
                    report($sformatf("write_back %b, want %b", m_tdata[28], want.wr));
            end
            n = no_idle ? 0 : $urandom_range(0, 5);
        end else if (n > 0) begin
            n = n - 1;
        end
        stall_left <= n;
        m_tready <= i_rst_n && (n == 0);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_alu_item x;
        // accumulator ops at their carry and zero corners
        ops_to_send.push_back(make_op(OP_ALU8, ALU_ADD, 8'hff, 8'h01, 4'h0, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ALU8, ALU_ADC, 8'h0f, 8'h00, 4'h1, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ALU8, ALU_SUB, 8'h00, 8'h01, 4'h0, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ALU8, ALU_SBC, 8'h10, 8'h0f, 4'h1, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ALU8, ALU_AND, 8'h00, 8'hff, 4'hf, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ALU8, ALU_XOR, 8'hff, 8'hff, 4'h0, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ALU8, ALU_OR, 8'h00, 8'h00, 4'hf, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ALU8, ALU_CP, 8'h42, 8'h42, 4'h0, 16'h0, 16'h0));
        for (int k = 0; k < 8; k++) begin
            ops_to_send.push_back(make_op(OP_SHIFT, SubW'(k), (k % 2) ? 8'h01 : 8'h80,
                                          8'h00, 4'h1, 16'h0, 16'h0));
        end
        ops_to_send.push_back(make_op(OP_BITTEST, 3'd7, 8'h7f, 8'h00, 4'h1, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_BITRESET, 3'd0, 8'hff, 8'h00, 4'hf, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_BITSET, 3'd7, 8'h00, 8'h00, 4'h0, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_INC, 3'd0, 8'hff, 8'h00, 4'h1, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_DEC, 3'd0, 8'h00, 8'h00, 4'h0, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_DAA, 3'd0, 8'h9a, 8'h00, 4'h0, 16'h0, 16'h0));
        // rotate kinds above three use only their low two bits, so seven runs as RRA
        ops_to_send.push_back(make_op(OP_ROTACC, 3'd7, 8'h01, 8'h00, 4'h1, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_CPL, 3'd0, 8'h5a, 8'h00, 4'h9, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_SCF, 3'd0, 8'h33, 8'h00, 4'he, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_CCF, 3'd0, 8'hcc, 8'h00, 4'h9, 16'h0, 16'h0));
        ops_to_send.push_back(make_op(OP_ADD16, 3'd0, 8'h00, 8'h00, 4'hf, 16'hffff, 16'h0001));
        ops_to_send.push_back(make_op(OP_ADDSPOFF, 3'd0, 8'h00, 8'h81, 4'hf, 16'h00ff, 16'h0));
        ops_to_send.push_back(make_op(OpSpareLo, 3'd5, 8'hff, 8'hff, 4'ha, 16'hffff, 16'hffff));
        ops_to_send.push_back(make_op(OpSpareHi, 3'd2, 8'h12, 8'h34, 4'h5, 16'h1234, 16'h5678));

        for (int k = 0; k < RandomOps; k++) begin
            x = make_op(OpW'($urandom_range(OP_ALU8, OP_ADDSPOFF)), SubW'($urandom_range(0, 7)),
                        pick_byte(), pick_byte(), FlagW'($urandom_range(0, 15)),
                        pick_word(), pick_word());
            if ($urandom_range(0, 99) == 0) begin
                x.op = OpW'($urandom_range(OpSpareLo, OpSpareHi));
            end
            ops_to_send.push_back(x);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_to_send.size() != 0 || s_tvalid) @(posedge i_clk);
        while (alu_results_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sm83_alu_flags_unit.f =====
+incdir+hdl
hdl/sm83_alu_pkg.sv
hdl/sm83_alu_flags_unit.sv
dv/sm83_alu_flags_unit_test.sv
